@@ hdl/asse_pkg.sv @@
package asse_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int SUM_W       = VALUE_WIDTH + AW;
  localparam int DIVIDEND_W  = SUM_W + 8;
  localparam int AVG_W       = 40;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_REM_IDX = 3'd1;
  localparam logic [2:0] CMD_REM_VAL = 3'd2;
  localparam logic [2:0] CMD_FIND    = 3'd3;
  localparam logic [2:0] CMD_SORT    = 3'd4;
  localparam logic [2:0] CMD_STATS   = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;
  localparam logic [2:0] CMD_FILL    = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INDEX    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_SHIFT  = 10'b0000000100,
    S_SORT_A = 10'b0000001000,
    S_SORT_B = 10'b0000010000,
    S_STATS  = 10'b0000100000,
    S_DIV    = 10'b0001000000,
    S_READ   = 10'b0010000000,
    S_FILL   = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

endpackage

@@ hdl/asse_ram.sv @@
module asse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/array_store_sort_engine_top.sv @@
// sequencing: append, fill with zero count and error cases go straight to the result; scans,
//   removal and read-out step through the stored words (one ram read port, registered read)
// sort: bubble passes over the store, up to count-1 passes (early exit)
// stats: accumulation over the stored words, then bit-serial division
// throughput: one command at a time; in_ready only while the sequencer is idle
// reset: rst clears count, sequencer and output valid; element ram is not cleared
module array_store_sort_engine_top
  import asse_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    command,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic [AW-1:0]                 index,
  input  logic                          descending,
  input  logic [CW-1:0]                 fill_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic signed [VALUE_WIDTH-1:0] element,
  output logic [AW-1:0]                 position,
  output logic signed [VALUE_WIDTH-1:0] minimum,
  output logic signed [VALUE_WIDTH-1:0] maximum,
  output logic signed [AVG_W-1:0]       average_q8,
  output logic [CW-1:0]                 length,
  output logic                          last
);

  state_t state;
  logic                          ph;        // 0: read issued, 1: read data back
  logic [CW-1:0]                 ptr;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 endp;      // bubble pass limit
  logic [CW-1:0]                 fillsat;
  logic [2:0]                    cmd_r;
  logic signed [VALUE_WIDTH-1:0] val_r;
  logic                          desc_r;
  logic                          swapped;
  logic signed [VALUE_WIDTH-1:0] a;         // element carried along the pass
  logic signed [VALUE_WIDTH-1:0] mn, mx;
  logic signed [SUM_W-1:0]       sum;
  logic [DIVIDEND_W-1:0]         dq;        // dividend shifting out, quotient in
  logic [CW:0]                   rem;
  logic                          neg;

  // pending result word
  logic [2:0]                    r_status;
  logic signed [VALUE_WIDTH-1:0] r_element;
  logic [AW-1:0]                 r_position;
  logic signed [VALUE_WIDTH-1:0] r_min, r_max;
  logic signed [AVG_W-1:0]       r_avg;
  logic                          r_last;

  // ram port
  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [VALUE_WIDTH-1:0]        wdata, rdata;
  logic signed [VALUE_WIDTH-1:0] rd_s;

  logic [CW-1:0]                 ptr1;
  logic                          swap;
  logic signed [SUM_W-1:0]       sum_nx;
  logic signed [VALUE_WIDTH-1:0] mn_nx, mx_nx;
  logic [SUM_W-1:0]              mag;
  logic [CW:0]                   remsh;
  logic                          out_free;

  asse_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_s     = signed'(rdata);
  assign ptr1     = ptr + CW'(1);
  assign swap     = desc_r ? (a < rd_s) : (a > rd_s);
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // running stats with the word just read
  assign sum_nx = ((ptr == '0) ? SUM_W'(0) : sum) + SUM_W'(rd_s);
  assign mn_nx  = (ptr == '0 || rd_s < mn) ? rd_s : mn;
  assign mx_nx  = (ptr == '0 || rd_s > mx) ? rd_s : mx;
  assign mag    = sum_nx[SUM_W-1] ? SUM_W'(-sum_nx) : SUM_W'(sum_nx);
  assign remsh  = {rem[CW-1:0], dq[DIVIDEND_W-1]};

  // ram control
  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = a;
    raddr = ptr[AW-1:0];
    case (state)
      S_IDLE: begin
        we    = in_valid && (command == CMD_APPEND) && (cnt < CW'(DEPTH));
        waddr = cnt[AW-1:0];
        wdata = value;
      end
      S_SHIFT: begin
        raddr = ptr1[AW-1:0];
        we    = ph && (ptr1 < cnt);
        wdata = rdata;
      end
      S_SORT_B: begin
        raddr = ptr1[AW-1:0];
        if (ptr1 >= endp) begin
          we    = 1'b1;                 // park the carried word at pass end
          wdata = a;
        end else begin
          we    = ph;
          wdata = swap ? rdata : a;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        wdata = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // emit loads the output itself, so only clear from other states
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= command;
            val_r      <= value;
            desc_r     <= descending;
            ptr        <= '0;
            ph         <= 1'b0;
            r_status   <= ST_OK;
            r_element  <= '0;
            r_position <= '0;
            r_min      <= '0;
            r_max      <= '0;
            r_avg      <= '0;
            r_last     <= 1'b1;
            state      <= S_EMIT;
            case (command)
              CMD_APPEND: begin
                if (cnt >= CW'(DEPTH)) begin
                  r_status <= ST_FULL;
                end else begin
                  cnt <= cnt + CW'(1);
                end
              end
              CMD_REM_IDX: begin
                if (CW'(index) >= cnt) begin
                  r_status <= ST_INDEX;
                end else begin
                  ptr   <= CW'(index);
                  state <= S_SHIFT;
                end
              end
              CMD_REM_VAL, CMD_FIND: begin
                if (cnt == '0) begin
                  r_status <= ST_NOTFOUND;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_SORT: begin
                endp <= cnt;
                if (cnt > CW'(1)) begin
                  state <= S_SORT_A;
                end
              end
              CMD_STATS: begin
                if (cnt == '0) begin
                  r_status <= ST_EMPTY;
                end else begin
                  state <= S_STATS;
                end
              end
              CMD_READ: begin
                if (cnt == '0) begin
                  r_status <= ST_EMPTY;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                // clear and fill, count saturates at depth
                if (fill_count > CW'(DEPTH)) begin
                  fillsat <= CW'(DEPTH);
                end else begin
                  fillsat <= fill_count;
                end
                if (fill_count == '0) begin
                  cnt <= '0;
                end else begin
                  state <= S_FILL;
                end
              end
            endcase
          end
        end

        S_SCAN: begin
          ph <= !ph;
          if (ph) begin
            if (rd_s == val_r) begin
              if (cmd_r == CMD_FIND) begin
                r_position <= ptr[AW-1:0];
                state      <= S_EMIT;
              end else begin
                state <= S_SHIFT;
              end
            end else if (ptr1 >= cnt) begin
              r_status <= ST_NOTFOUND;
              state    <= S_EMIT;
            end else begin
              ptr <= ptr1;
            end
          end
        end

        S_SHIFT: begin
          if (ptr1 >= cnt) begin
            cnt   <= cnt - CW'(1);
            ph    <= 1'b0;
            state <= S_EMIT;
          end else begin
            ph <= !ph;
            if (ph) begin
              ptr <= ptr1;
            end
          end
        end

        S_SORT_A: begin
          ph <= !ph;
          if (ph) begin
            a       <= rd_s;
            swapped <= 1'b0;
            state   <= S_SORT_B;
          end
        end

        S_SORT_B: begin
          if (ptr1 >= endp) begin
            endp <= endp - CW'(1);
            ptr  <= '0;
            ph   <= 1'b0;
            // early exit once a pass makes no swap
            if (swapped && (endp - CW'(1)) > CW'(1)) begin
              state <= S_SORT_A;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            ph <= !ph;
            if (ph) begin
              ptr <= ptr1;
              if (swap) begin
                swapped <= 1'b1;
              end else begin
                a <= rd_s;
              end
            end
          end
        end

        S_STATS: begin
          ph <= !ph;
          if (ph) begin
            sum <= sum_nx;
            mn  <= mn_nx;
            mx  <= mx_nx;
            if (ptr1 >= cnt) begin
              r_min <= mn_nx;
              r_max <= mx_nx;
              neg   <= sum_nx[SUM_W-1];
              dq    <= {mag, 8'd0};
              rem   <= '0;
              ptr   <= '0;
              state <= S_DIV;
            end else begin
              ptr <= ptr1;
            end
          end
        end

        S_DIV: begin
          // restoring division of |sum*256| by count, one quotient bit per cycle
          if (ptr == CW'(DIVIDEND_W)) begin
            r_avg <= neg ? -signed'(dq[AVG_W-1:0]) : signed'(dq[AVG_W-1:0]);
            state <= S_EMIT;
          end else begin
            ptr <= ptr1;
            if (remsh >= {1'b0, cnt}) begin
              rem <= remsh - {1'b0, cnt};
              dq  <= {dq[DIVIDEND_W-2:0], 1'b1};
            end else begin
              rem <= remsh;
              dq  <= {dq[DIVIDEND_W-2:0], 1'b0};
            end
          end
        end

        S_READ: begin
          ph <= !ph;
          if (ph) begin
            r_element  <= rd_s;
            r_position <= ptr[AW-1:0];
            r_last     <= (ptr1 == cnt);
            state      <= S_EMIT;
          end
        end

        S_FILL: begin
          ptr <= ptr1;
          if (ptr1 >= fillsat) begin
            cnt   <= fillsat;
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= r_status;
            element    <= r_element;
            position   <= r_position;
            minimum    <= r_min;
            maximum    <= r_max;
            average_q8 <= r_avg;
            length     <= cnt;
            last       <= r_last;
            if (cmd_r == CMD_READ && !r_last) begin
              ptr   <= ptr1;
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the store never holds more words than its depth
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("element count above depth");

  // ram writes only come from states that modify the store
  assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_IDLE || state == S_SHIFT || state == S_SORT_B || state == S_FILL))
    else $error("ram write from a read-only state");

  // the divider never runs past the dividend width
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (ptr <= CW'(DIVIDEND_W)))
    else $error("divider step count overrun");

  // a new result word is only loaded when the output is free
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !out_ready) |=> (state == S_EMIT))
    else $error("result dropped while output stalled");

endmodule

@@ verif/array_store_sort_engine_top_tb.sv @@
module array_store_sort_engine_top_tb;
  import asse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // block ports
  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [2:0]                    command;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [AW-1:0]                 index;
  logic                          descending;
  logic [CW-1:0]                 fill_count;
  logic                          out_valid;
  logic                          out_ready;
  logic [2:0]                    status;
  logic signed [VALUE_WIDTH-1:0] element;
  logic [AW-1:0]                 position;
  logic signed [VALUE_WIDTH-1:0] minimum;
  logic signed [VALUE_WIDTH-1:0] maximum;
  logic signed [AVG_W-1:0]       average_q8;
  logic [CW-1:0]                 length;
  logic                          last;

  array_store_sort_engine_top dut (.*);

  // one result word as the block should present it
  typedef struct {
    logic [2:0]              status;
    logic [VALUE_WIDTH-1:0]  element;
    logic [AW-1:0]           position;
    logic [VALUE_WIDTH-1:0]  minimum;
    logic [VALUE_WIDTH-1:0]  maximum;
    logic [AVG_W-1:0]        average_q8;
    logic [CW-1:0]           length;
    logic                    last;
  } result_word_t;

  // directed stimulus row; typed expectations only for the obvious cases
  typedef struct {
    logic [2:0]              cmd;
    logic [VALUE_WIDTH-1:0]  val;
    logic [AW-1:0]           idx;
    logic                    desc;
    logic [CW-1:0]           fill;
    bit                      typed;
    logic [2:0]              exp_status;
    logic [CW-1:0]           exp_length;
  } cmd_row_t;

  // shadow copy of the store
  logic signed [VALUE_WIDTH-1:0] shadow_store [DEPTH];
  int                            shadow_count;

  result_word_t pending_results [$];
  int           mismatches;
  int           words_seen;
  bit           send_calm;
  bit           recv_calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well above the slowest legal run
  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic result_word_t blank_word(logic [2:0] st);
    result_word_t w;
    w.status     = st;
    w.element    = '0;
    w.position   = '0;
    w.minimum    = '0;
    w.maximum    = '0;
    w.average_q8 = '0;
    w.length     = shadow_count[CW-1:0];
    w.last       = 1'b1;
    return w;
  endfunction

  // first index holding v, or -1 when absent
  function automatic int locate(logic signed [VALUE_WIDTH-1:0] v);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_store[i] == v) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int p);
    for (int i = p; i + 1 < shadow_count; i++) shadow_store[i] = shadow_store[i + 1];
    shadow_count--;
  endfunction

  // store behavior for one accepted command word; queues every result it causes
  function automatic void apply_command(logic [2:0] cmd, logic signed [VALUE_WIDTH-1:0] v,
                                        logic [AW-1:0] idx, logic desc, logic [CW-1:0] fill);
    result_word_t w;
    int p;
    int stop;
    bit swapped;
    logic signed [VALUE_WIDTH-1:0] a, b, lo, hi;
    longint sum;
    longint avg;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_count >= DEPTH) begin
          pending_results.push_back(blank_word(ST_FULL));
        end else begin
          shadow_store[shadow_count] = v;
          shadow_count++;
          pending_results.push_back(blank_word(ST_OK));
        end
      end
      CMD_REM_IDX: begin
        if (idx >= shadow_count) begin
          pending_results.push_back(blank_word(ST_INDEX));
        end else begin
          drop_entry(idx);
          pending_results.push_back(blank_word(ST_OK));
        end
      end
      CMD_REM_VAL: begin
        p = locate(v);
        if (p < 0) begin
          pending_results.push_back(blank_word(ST_NOTFOUND));
        end else begin
          drop_entry(p);
          pending_results.push_back(blank_word(ST_OK));
        end
      end
      CMD_FIND: begin
        p = locate(v);
        if (p < 0) begin
          pending_results.push_back(blank_word(ST_NOTFOUND));
        end else begin
          w = blank_word(ST_OK);
          w.position = p[AW-1:0];
          pending_results.push_back(w);
        end
      end
      CMD_SORT: begin
        // bubble passes with early exit when a pass swaps nothing
        swapped = 1'b1;
        stop = shadow_count;
        while (swapped && stop > 1) begin
          swapped = 1'b0;
          for (int i = 0; i + 1 < stop; i++) begin
            a = shadow_store[i];
            b = shadow_store[i + 1];
            if (desc ? (a < b) : (a > b)) begin
              shadow_store[i]     = b;
              shadow_store[i + 1] = a;
              swapped = 1'b1;
            end
          end
          stop--;
        end
        pending_results.push_back(blank_word(ST_OK));
      end
      CMD_STATS: begin
        if (shadow_count == 0) begin
          pending_results.push_back(blank_word(ST_EMPTY));
        end else begin
          lo = shadow_store[0];
          hi = shadow_store[0];
          sum = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_store[i] < lo) lo = shadow_store[i];
            if (shadow_store[i] > hi) hi = shadow_store[i];
            sum += longint'(shadow_store[i]);
          end
          // longint division truncates toward zero
          avg = (sum * 256) / longint'(shadow_count);
          w = blank_word(ST_OK);
          w.minimum    = lo;
          w.maximum    = hi;
          w.average_q8 = avg[AVG_W-1:0];
          pending_results.push_back(w);
        end
      end
      CMD_READ: begin
        if (shadow_count == 0) begin
          pending_results.push_back(blank_word(ST_EMPTY));
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            w = blank_word(ST_OK);
            w.element  = shadow_store[i];
            w.position = i[AW-1:0];
            w.last     = (i + 1 == shadow_count);
            pending_results.push_back(w);
          end
        end
      end
      default: begin
        // clear-and-fill, count saturates at the store depth
        for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
        shadow_count = (fill > DEPTH) ? DEPTH : int'(fill);
        pending_results.push_back(blank_word(ST_OK));
      end
    endcase
  endfunction

  // gap draw; calm stretches give back-to-back traffic
  function automatic int draw_gap(ref bit calm);
    if ($urandom_range(0, 19) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // offer one command word and wait for it to be taken
  task automatic offer_word(cmd_row_t r);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= r.cmd;
    value      <= r.val;
    index      <= r.idx;
    descending <= r.desc;
    fill_count <= r.fill;
    do @(posedge clk); while (!in_ready);
    apply_command(r.cmd, r.val, r.idx, r.desc, r.fill);
    if (r.typed) begin
      pending_results[$].status = r.exp_status;
      pending_results[$].length = r.exp_length;
    end
  endtask

  function automatic cmd_row_t make_row(logic [2:0] c, logic [31:0] v, int i, bit d, int f,
                                        bit t = 0, logic [2:0] es = ST_OK, int el = 0);
    cmd_row_t r;
    r.cmd = c; r.val = v; r.idx = i[AW-1:0]; r.desc = d; r.fill = f[CW-1:0];
    r.typed = t; r.exp_status = es; r.exp_length = el[CW-1:0];
    return r;
  endfunction

  // random command word, biased toward well-formed traffic on a small store
  function automatic cmd_row_t random_row();
    cmd_row_t r;
    int pick;
    int ri;
    int rf;
    logic [31:0] pool [8] = '{32'd0, 32'd1, -32'sd1, 32'd7, 32'h7fffffff, 32'h80000000,
                              32'd1000, -32'sd1000};
    pick = $urandom_range(0, 99);
    r = make_row(CMD_APPEND, '0, 0, 0, 0);
    r.val  = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : $urandom;
    ri     = (shadow_count > 0 && $urandom_range(0, 1)) ?
             $urandom_range(0, shadow_count - 1) : $urandom_range(0, 63);
    r.idx  = ri[AW-1:0];
    r.desc = 1'($urandom_range(0, 1));
    rf     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
    r.fill = rf[CW-1:0];
    if (shadow_count > 0 && $urandom_range(0, 1) && pick >= 20 && pick < 60)
      r.val = shadow_store[$urandom_range(0, shadow_count - 1)];
    if (pick < 35)      r.cmd = (shadow_count > 24) ? CMD_REM_IDX : CMD_APPEND;
    else if (pick < 45) r.cmd = CMD_REM_IDX;
    else if (pick < 55) r.cmd = CMD_REM_VAL;
    else if (pick < 65) r.cmd = CMD_FIND;
    else if (pick < 75) r.cmd = CMD_SORT;
    else if (pick < 83) r.cmd = CMD_STATS;
    else if (pick < 92) r.cmd = CMD_READ;
    else                r.cmd = CMD_FILL;
    return r;
  endfunction

  // receiver: random back-pressure plus one long hold-off so the block backs up
  initial begin
    int gap;
    result_word_t exp_w;
    bit bad;
    out_ready  = 1'b0;
    words_seen = 0;
    mismatches = 0;
    recv_calm  = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (words_seen == 30) gap = 400;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      words_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, status %0d", status);
      end else begin
        exp_w = pending_results.pop_front();
        bad = (status !== exp_w.status) || (element !== exp_w.element) ||
              (position !== exp_w.position) || (minimum !== exp_w.minimum) ||
              (maximum !== exp_w.maximum) || (average_q8 !== exp_w.average_q8) ||
              (length !== exp_w.length) || (last !== exp_w.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word %0d exp st=%0d el=%h pos=%0d min=%h max=%h avg=%h len=%0d last=%b",
                     words_seen, exp_w.status, exp_w.element, exp_w.position, exp_w.minimum,
                     exp_w.maximum, exp_w.average_q8, exp_w.length, exp_w.last);
            $display("        got st=%0d el=%h pos=%0d min=%h max=%h avg=%h len=%0d last=%b",
                     status, element, position, minimum, maximum, average_q8, length, last);
          end
        end
      end
    end
  end

  // sender: directed table, then random traffic, then drain and verdict
  initial begin
    cmd_row_t directed [$];
    int n;
    in_valid     = 1'b0;
    command      = CMD_APPEND;
    value        = '0;
    index        = '0;
    descending   = 1'b0;
    fill_count   = '0;
    shadow_count = 0;
    send_calm    = 1'b0;
    rst          = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store error paths and an empty store sort
    directed.push_back(make_row(CMD_STATS,   0, 0, 0, 0, 1, ST_EMPTY, 0));
    directed.push_back(make_row(CMD_READ,    0, 0, 0, 0, 1, ST_EMPTY, 0));
    directed.push_back(make_row(CMD_REM_IDX, 0, 0, 0, 0, 1, ST_INDEX, 0));
    directed.push_back(make_row(CMD_FIND,    5, 0, 0, 0, 1, ST_NOTFOUND, 0));
    directed.push_back(make_row(CMD_REM_VAL, 5, 0, 0, 0, 1, ST_NOTFOUND, 0));
    directed.push_back(make_row(CMD_SORT,    0, 0, 1, 0, 1, ST_OK, 0));
    // value extremes
    directed.push_back(make_row(CMD_APPEND, 32'h7fffffff, 0, 0, 0, 1, ST_OK, 1));
    directed.push_back(make_row(CMD_APPEND, 32'h80000000, 0, 0, 0, 1, ST_OK, 2));
    directed.push_back(make_row(CMD_APPEND, 32'hffffffff, 0, 0, 0, 1, ST_OK, 3));
    directed.push_back(make_row(CMD_APPEND, 32'h0,        0, 0, 0, 1, ST_OK, 4));
    directed.push_back(make_row(CMD_FIND,   32'hffffffff, 0, 0, 0));
    directed.push_back(make_row(CMD_SORT,   0, 0, 0, 0));
    directed.push_back(make_row(CMD_READ,   0, 0, 0, 0));
    directed.push_back(make_row(CMD_STATS,  0, 0, 0, 0));
    directed.push_back(make_row(CMD_SORT,   0, 0, 1, 0));
    directed.push_back(make_row(CMD_READ,   0, 0, 0, 0));
    directed.push_back(make_row(CMD_REM_IDX, 0, 63, 0, 0, 1, ST_INDEX, 4));
    directed.push_back(make_row(CMD_REM_IDX, 0, 1, 0, 0));
    directed.push_back(make_row(CMD_REM_VAL, 32'h80000000, 0, 0, 0));
    // fill above depth saturates, then the full store
    directed.push_back(make_row(CMD_FILL,   0, 0, 0, 127, 1, ST_OK, 64));
    directed.push_back(make_row(CMD_APPEND, 9, 0, 0, 0, 1, ST_FULL, 64));
    directed.push_back(make_row(CMD_STATS,  0, 0, 0, 0));
    directed.push_back(make_row(CMD_FILL,   0, 0, 0, 0, 1, ST_OK, 0));
    // single element sort
    directed.push_back(make_row(CMD_FILL,   0, 0, 0, 1, 1, ST_OK, 1));
    directed.push_back(make_row(CMD_SORT,   0, 0, 1, 0, 1, ST_OK, 1));

    foreach (directed[k]) offer_word(directed[k]);

    // random traffic; shrink back from a full store so sorts stay cheap
    n = 0;
    while (n < 235) begin
      offer_word(random_row());
      n++;
    end
    @(posedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
